// ===== rtl/core/rhc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

    // One pixel request on the input side.
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    // One converted result on the output side.
    typedef struct packed {
        logic [8:0] hue_out;
        logic [7:0] saturation_out;
        logic [7:0] lightness_out;
    } hsl_t;

    // Divider geometry: one quotient bit per stage.
    localparam int DIV_QUO_W   = 8;
    localparam int HUE_NUM_W   = 16;
    localparam int SAT_NUM_W   = 17;
    localparam int DIV_DEN_W   = 9;

    // Sector bases in degrees.
    localparam logic [8:0] HUE_BASE_RED      = 9'd0;
    localparam logic [8:0] HUE_BASE_RED_WRAP = 9'd360;
    localparam logic [8:0] HUE_BASE_GREEN    = 9'd120;
    localparam logic [8:0] HUE_BASE_BLUE     = 9'd240;

endpackage : rhc_pkg

`default_nettype wire

// ===== rtl/core/rhc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per register stage.
// Caller guarantees num < den * 2**QUO_W.
module rhc_div #(
    parameter int NUM_W = rhc_pkg::SAT_NUM_W,
    parameter int DEN_W = rhc_pkg::DIV_DEN_W,
    parameter int QUO_W = rhc_pkg::DIV_QUO_W
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo
);

    localparam int CW = (NUM_W > DEN_W + QUO_W - 1) ? NUM_W : DEN_W + QUO_W - 1;

    logic [NUM_W-1:0] rem_reg [QUO_W-1];
    logic [DEN_W-1:0] den_reg [QUO_W-1];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [CW-1:0]    shifted;
        logic [CW:0]      diff;
        logic [QUO_W-1:0] quo_next;
        logic [NUM_W-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign shifted = CW'(den_in) << (QUO_W - 1 - k);
        assign diff    = {1'b0, CW'(rem_in)} - {1'b0, shifted};

        always_comb
        begin
            quo_next = quo_in;
            quo_next[QUO_W-1-k] = ~diff[CW];
            rem_next = diff[CW] ? rem_in : diff[NUM_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= quo_next;
            end
        end

        if (k < QUO_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule : rhc_div

`default_nettype wire

// ===== rtl/core/rgb_to_hsl_converter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Path from pixel request to result: the front stages, the dividers, then the output register.
// Throughput: one pixel per cycle unless stalled; the two 8-stage dividers are fully pipelined.
// A stall on the output freezes the whole pipeline only while the output register is full.
// Reset (rst_n, asynchronous, active low) clears all valid bits; payload is not reset.
module rgb_to_hsl_converter_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pixel_valid,
    output logic                pixel_stall,
    input  wire rhc_pkg::pixel_t pixel,
    output logic                hsl_valid,
    input  wire logic           hsl_stall,
    output rhc_pkg::hsl_t       hsl
);

    import rhc_pkg::*;

    // Front stage 1: extremes and sector of the pixel.
    typedef struct packed {
        logic [7:0]        delta;
        logic [8:0]        sum;
        logic signed [8:0] diff;
        logic [8:0]        base;
    } front_t;

    // Side data carried alongside the dividers.
    typedef struct packed {
        logic       gray;
        logic [8:0] base;
        logic [7:0] light;
    } side_t;

    logic   en;

    // Stage 1
    logic   v1_reg;
    front_t f1_reg;
    front_t f1_next;

    // Stage 2 (divider operands)
    logic                 v2_reg;
    side_t                s2_reg;
    side_t                s2_next;
    logic [HUE_NUM_W-1:0] hnum_reg;
    logic [HUE_NUM_W-1:0] hnum_next;
    logic [SAT_NUM_W-1:0] snum_reg;
    logic [SAT_NUM_W-1:0] snum_next;
    logic [DIV_DEN_W-1:0] hden_reg;
    logic [DIV_DEN_W-1:0] sden_reg;
    logic [7:0]           den8;

    // Divider stages
    logic  vd_reg [DIV_QUO_W];
    side_t sd_reg [DIV_QUO_W];
    logic [DIV_QUO_W-1:0] hue_q;
    logic [DIV_QUO_W-1:0] sat_q;

    // Output register
    logic  out_valid_reg;
    hsl_t  out_reg;
    hsl_t  out_next;
    logic [9:0] hue_sum;

    // Advance whenever the output register is empty or being taken.
    assign en          = ~out_valid_reg | ~hsl_stall;
    assign pixel_stall = ~en;

    // Stage 1: max, min, delta and the sector; red wins ties over green, green over blue.
    always_comb
    begin
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] hi;
        logic [7:0] lo;
        r  = pixel.red_in;
        g  = pixel.green_in;
        b  = pixel.blue_in;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        f1_next.delta = hi - lo;
        f1_next.sum   = {1'b0, hi} + {1'b0, lo};
        if (hi == r)
        begin
            f1_next.diff = $signed({1'b0, g}) - $signed({1'b0, b});
            // Wrap a negative red-sector hue into the upper turn.
            f1_next.base = f1_next.diff[8] ? HUE_BASE_RED_WRAP : HUE_BASE_RED;
        end
        else if (hi == g)
        begin
            f1_next.diff = $signed({1'b0, b}) - $signed({1'b0, r});
            f1_next.base = HUE_BASE_GREEN;
        end
        else
        begin
            f1_next.diff = $signed({1'b0, r}) - $signed({1'b0, g});
            f1_next.base = HUE_BASE_BLUE;
        end
    end

    // Stage 2: divider operands.
    // Hue: base - 60 + floor((120*diff + 121*delta) / (2*delta)), numerator always >= 0.
    // Saturation: floor((510*delta + den) / (2*den)), den = 255 - |sum - 255|.
    always_comb
    begin
        logic signed [17:0] d_ext;
        logic signed [17:0] dl_ext;
        logic signed [17:0] h_wide;
        logic [17:0]        s_wide;
        d_ext  = 18'($signed(f1_reg.diff));
        dl_ext = $signed({10'b0, f1_reg.delta});
        h_wide = d_ext * 18'sd120 + dl_ext * 18'sd121;
        den8   = (f1_reg.sum <= 9'd255) ? f1_reg.sum[7:0] : 8'(10'd510 - {1'b0, f1_reg.sum});
        s_wide = {10'b0, f1_reg.delta} * 18'd510 + {10'b0, den8};
        hnum_next     = h_wide[HUE_NUM_W-1:0];
        snum_next     = s_wide[SAT_NUM_W-1:0];
        s2_next.gray  = (f1_reg.delta == 8'd0);
        s2_next.base  = f1_reg.base;
        s2_next.light = 8'((10'(f1_reg.sum) + 10'd1) >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= pixel_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= vd_reg[DIV_QUO_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg   <= f1_next;
            s2_reg   <= s2_next;
            hnum_reg <= hnum_next;
            snum_reg <= snum_next;
            hden_reg <= {1'b0, f1_reg.delta} << 1;
            sden_reg <= {1'b0, den8} << 1;
            out_reg  <= out_next;
        end
    end

    // Valid bits and side data track the divider stages.
    for (genvar k = 0; k < DIV_QUO_W; k++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vd_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vd_reg[k] <= (k == 0) ? v2_reg : vd_reg[(k == 0) ? 0 : k - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sd_reg[k] <= (k == 0) ? s2_reg : sd_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    rhc_div #(
        .NUM_W (HUE_NUM_W),
        .DEN_W (DIV_DEN_W),
        .QUO_W (DIV_QUO_W)
    ) u_hue_div (
        .clk (clk),
        .en  (en),
        .num (hnum_reg),
        .den (hden_reg),
        .quo (hue_q)
    );

    rhc_div #(
        .NUM_W (SAT_NUM_W),
        .DEN_W (DIV_DEN_W),
        .QUO_W (DIV_QUO_W)
    ) u_sat_div (
        .clk (clk),
        .en  (en),
        .num (snum_reg),
        .den (sden_reg),
        .quo (sat_q)
    );

    // Output stage: assemble hue, fold 360 back to 0, and zero hue and saturation for gray.
    always_comb
    begin
        hue_sum = {1'b0, sd_reg[DIV_QUO_W-1].base} + {2'b0, hue_q} - 10'd60;
        if (hue_sum >= 10'd360)
        begin
            hue_sum = hue_sum - 10'd360;
        end
        out_next.lightness_out = sd_reg[DIV_QUO_W-1].light;
        if (sd_reg[DIV_QUO_W-1].gray)
        begin
            out_next.hue_out        = 9'd0;
            out_next.saturation_out = 8'd0;
        end
        else
        begin
            out_next.hue_out        = hue_sum[8:0];
            out_next.saturation_out = sat_q;
        end
    end

    assign hsl_valid = out_valid_reg;
    assign hsl       = out_reg;

endmodule : rgb_to_hsl_converter_core

`default_nettype wire
